FILE: src/bvs_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and discharge table for the battery voltage to soc block
// no dependencies
package bvs_pkg;

  localparam int TABLE_POINTS = 9;
  localparam int VOLT_BITS    = 14;
  localparam int SEGS         = TABLE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGS);
  localparam int PT_W         = $clog2(TABLE_POINTS);
  localparam int SOC_W        = 7;
  localparam int DIFF_W       = 10;
  localparam int SLOPE_W      = 5;
  localparam int NUM_W        = 14;
  localparam int RECIP_SHIFT  = 26;
  localparam int RECIP_W      = 19;
  localparam int QUOT_W       = 5;

  typedef logic [VOLT_BITS-1:0] volt_t;
  typedef logic [SOC_W-1:0]     soc_t;
  typedef logic [SEG_W-1:0]     seg_t;
  typedef logic [DIFF_W-1:0]    diff_t;
  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [RECIP_W-1:0]   recip_t;
  typedef logic [QUOT_W-1:0]    quot_t;

  localparam soc_t SOC_MAX = soc_t'(100);

  localparam volt_t CURVE_MV [TABLE_POINTS] = '{
    volt_t'(6000), volt_t'(6600), volt_t'(6900), volt_t'(7100), volt_t'(7300),
    volt_t'(7400), volt_t'(7600), volt_t'(8000), volt_t'(8400)
  };

  localparam soc_t CURVE_SOC [TABLE_POINTS] = '{
    soc_t'(0), soc_t'(5), soc_t'(15), soc_t'(35), soc_t'(55),
    soc_t'(70), soc_t'(85), soc_t'(95), soc_t'(100)
  };

  // twice the segment width, the divisor of the rounded quotient
  localparam longint SegDen2 [SEGS] = '{
    2 * (longint'(CURVE_MV[1]) - longint'(CURVE_MV[0])),
    2 * (longint'(CURVE_MV[2]) - longint'(CURVE_MV[1])),
    2 * (longint'(CURVE_MV[3]) - longint'(CURVE_MV[2])),
    2 * (longint'(CURVE_MV[4]) - longint'(CURVE_MV[3])),
    2 * (longint'(CURVE_MV[5]) - longint'(CURVE_MV[4])),
    2 * (longint'(CURVE_MV[6]) - longint'(CURVE_MV[5])),
    2 * (longint'(CURVE_MV[7]) - longint'(CURVE_MV[6])),
    2 * (longint'(CURVE_MV[8]) - longint'(CURVE_MV[7]))
  };

  localparam longint RecipOne = longint'(1) << RECIP_SHIFT;

  // ceil(2^shift / divisor), exact floor for every numerator below 2^NUM_W
  localparam recip_t SEG_RECIP [SEGS] = '{
    recip_t'((RecipOne + SegDen2[0] - 1) / SegDen2[0]),
    recip_t'((RecipOne + SegDen2[1] - 1) / SegDen2[1]),
    recip_t'((RecipOne + SegDen2[2] - 1) / SegDen2[2]),
    recip_t'((RecipOne + SegDen2[3] - 1) / SegDen2[3]),
    recip_t'((RecipOne + SegDen2[4] - 1) / SegDen2[4]),
    recip_t'((RecipOne + SegDen2[5] - 1) / SegDen2[5]),
    recip_t'((RecipOne + SegDen2[6] - 1) / SegDen2[6]),
    recip_t'((RecipOne + SegDen2[7] - 1) / SegDen2[7])
  };

  typedef enum logic [1:0] {
    RANGE_MID,
    RANGE_LOW,
    RANGE_HIGH
  } range_t;

  typedef struct packed {
    range_t range;
    seg_t   seg;
    diff_t  diff;
  } loc_t;

  function automatic diff_t seg_den(input seg_t seg);
    logic [PT_W-1:0] hi;
    hi = PT_W'(seg) + PT_W'(1);
    return diff_t'(CURVE_MV[hi] - CURVE_MV[seg]);
  endfunction

  function automatic logic [SLOPE_W-1:0] seg_rise(input seg_t seg);
    logic [PT_W-1:0] hi;
    hi = PT_W'(seg) + PT_W'(1);
    return SLOPE_W'(CURVE_SOC[hi] - CURVE_SOC[seg]);
  endfunction

endpackage

FILE: src/battery_voltage_to_soc.sv
`timescale 1ns / 1ps
// top level: battery voltage in millivolts to state of charge in percent
// depends on bvs_pkg, bvs_locate, bvs_interp
//
// usage
//   input channel: in_valid, in_stall, in_vbat_mv (14-bit unsigned millivolts)
//   result channel: out_valid, out_stall, out_soc_percent (0..100)
//   a beat moves on a channel at a clock edge with valid high and stall low
//   one result beat for every input beat, in order
//   five-stage pipeline: segment search, segment offset, rounded numerator,
//   reciprocal multiply, offset add and clamp
//   with no stall an input beat passes each stage register in turn, and out_valid
//   rises when the beat is registered in the last stage
//   throughput is one beat per cycle while out_stall is low, every stage then moving a beat each cycle
//   below 6000 mV the result is 0, above 8400 mV it is 100
//   a stall on the result side holds the last stage; earlier stages keep
//   filling until they hold a beat, so in_stall rises only when the pipe is full
//   synchronous reset clears all stage valid bits; data registers are not reset
module battery_voltage_to_soc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bvs_pkg::volt_t        in_vbat_mv,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bvs_pkg::soc_t         out_soc_percent
);
  import bvs_pkg::*;

  logic  loc_valid;
  logic  loc_stall;
  loc_t  loc;

  bvs_locate u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_vbat_mv (in_vbat_mv),
    .out_valid  (loc_valid),
    .out_stall  (loc_stall),
    .out_loc    (loc)
  );

  bvs_interp u_interp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (loc_valid),
    .in_stall        (loc_stall),
    .in_loc          (loc),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_soc_percent (out_soc_percent)
  );

endmodule

FILE: src/bvs_locate.sv
`timescale 1ns / 1ps
// two pipeline stages: segment search against the breakpoints, then offset into the segment
// depends on bvs_pkg
module bvs_locate (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bvs_pkg::volt_t        in_vbat_mv,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bvs_pkg::loc_t         out_loc
);
  import bvs_pkg::*;

  logic                v1_r;
  volt_t               volt1_r;
  seg_t                seg1_r;
  range_t              range1_r;
  logic                v2_r;
  loc_t                loc2_r;

  logic                adv1;
  logic                adv2;
  logic [SEGS-2:0]     above;
  seg_t                seg_nxt;
  range_t              range_nxt;
  loc_t                loc_nxt;

  assign adv2     = !v2_r || !out_stall;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // at a breakpoint the lower segment wins
  always_comb begin
    for (int i = 0; i < SEGS - 1; i++) begin
      above[i] = in_vbat_mv > CURVE_MV[i+1];
    end
    seg_nxt = SEG_W'($countones(above));
    priority if (in_vbat_mv <= CURVE_MV[0]) begin
      range_nxt = RANGE_LOW;
    end else if (in_vbat_mv >= CURVE_MV[TABLE_POINTS-1]) begin
      range_nxt = RANGE_HIGH;
    end else begin
      range_nxt = RANGE_MID;
    end
  end

  always_comb begin
    loc_nxt.range = range1_r;
    loc_nxt.seg   = seg1_r;
    loc_nxt.diff  = '0;
    if (range1_r == RANGE_MID) begin
      loc_nxt.diff = diff_t'(volt1_r - CURVE_MV[seg1_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      volt1_r  <= in_vbat_mv;
      seg1_r   <= seg_nxt;
      range1_r <= range_nxt;
    end
    if (adv2 && v1_r) begin
      loc2_r <= loc_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_loc   = loc2_r;

  a_diff_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && loc2_r.range == RANGE_MID) |-> (loc2_r.diff <= seg_den(loc2_r.seg)))
    else $error("offset past end of segment");

  a_mid_not_first_point: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && range1_r == RANGE_MID) |-> (volt1_r > CURVE_MV[seg1_r]))
    else $error("segment start not below sample");

endmodule

FILE: src/bvs_interp.sv
`timescale 1ns / 1ps
// three pipeline stages: rounded numerator, reciprocal multiply, offset add and clamp
// depends on bvs_pkg
module bvs_interp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bvs_pkg::loc_t         in_loc,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bvs_pkg::soc_t         out_soc_percent
);
  import bvs_pkg::*;

  logic                          v3_r;
  num_t                          num3_r;
  seg_t                          seg3_r;
  range_t                        range3_r;
  logic                          v4_r;
  quot_t                         quot4_r;
  seg_t                          seg4_r;
  range_t                        range4_r;
  logic                          v5_r;
  soc_t                          soc5_r;

  logic                          adv3;
  logic                          adv4;
  logic                          adv5;
  logic [DIFF_W+SLOPE_W:0]       scaled;
  num_t                          num_nxt;
  logic [NUM_W+RECIP_W-1:0]      prod;
  soc_t                          sum;
  soc_t                          soc_nxt;

  assign adv5     = !v5_r || !out_stall;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign in_stall = !adv3;

  // 2*d*rise + width, divided later by 2*width for round half up
  always_comb begin
    scaled  = {in_loc.diff, 1'b0} * seg_rise(in_loc.seg);
    num_nxt = num_t'(scaled + {{(SLOPE_W+1){1'b0}}, seg_den(in_loc.seg)});
  end

  assign prod = num3_r * SEG_RECIP[seg3_r];

  always_comb begin
    sum = CURVE_SOC[seg4_r] + soc_t'(quot4_r);
    unique case (range4_r)
      RANGE_LOW:  soc_nxt = CURVE_SOC[0];
      RANGE_HIGH: soc_nxt = CURVE_SOC[TABLE_POINTS-1];
      RANGE_MID:  soc_nxt = sum;
      default:    soc_nxt = sum;
    endcase
    if (soc_nxt > SOC_MAX) begin
      soc_nxt = SOC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= in_valid;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      num3_r   <= num_nxt;
      seg3_r   <= in_loc.seg;
      range3_r <= in_loc.range;
    end
    if (adv4 && v3_r) begin
      quot4_r  <= prod[RECIP_SHIFT +: QUOT_W];
      seg4_r   <= seg3_r;
      range4_r <= range3_r;
    end
    if (adv5 && v4_r) begin
      soc5_r <= soc_nxt;
    end
  end

  assign out_valid       = v5_r;
  assign out_soc_percent = soc5_r;

  a_quot_within_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && range4_r == RANGE_MID) |-> (SLOPE_W'(quot4_r) <= seg_rise(seg4_r)))
    else $error("interpolated step exceeds segment rise");

  a_soc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (soc5_r <= SOC_MAX))
    else $error("soc out of range");

endmodule
